>>> rtl/acmf_pkg.sv
// shared widths and codes for the alarm clock menu controller
// no dependencies; imported by alarm_clock_menu_fsm_core, acmf_screen_check and the testbench
`timescale 1ns / 1ps
`default_nettype none

package acmf_pkg;

   localparam int MODE_W   = 3;
   localparam int SCREEN_W = 4;
   localparam int CFG_W    = 20;
   localparam int CFG_IDX_W = 2;
   localparam int TMR_W    = 22;
   localparam int ADJ_W    = 3;
   localparam int DIR_W    = 2;

   // event codes
   localparam logic [MODE_W-1:0] MODE_PRESS     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TICK      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_KNOB_UP   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_KNOB_DOWN = 3'd4;
   localparam logic [MODE_W-1:0] MODE_EXPIRED   = 3'd5;

   // adjustment targets
   localparam logic [ADJ_W-1:0] ADJ_NONE   = 3'd0;
   localparam logic [ADJ_W-1:0] ADJ_ALARM  = 3'd1;
   localparam logic [ADJ_W-1:0] ADJ_SNOOZE = 3'd2;
   localparam logic [ADJ_W-1:0] ADJ_BRIGHT = 3'd3;
   localparam logic [ADJ_W-1:0] ADJ_AUTO   = 3'd4;

   // adjustment directions, two's complement
   localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sd0;
   localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sd1;
   localparam logic signed [DIR_W-1:0] DIR_DOWN = -2'sd1;

   // configuration register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MENU = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_MENU       = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOLD = 2'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_AP_HOLD    = 2'd3;

   localparam logic [CFG_W-1:0] SHORT_MENU_RST = 20'd2000;
   localparam logic [CFG_W-1:0] MENU_RST       = 20'd10000;
   localparam logic [CFG_W-1:0] ALARM_HOLD_RST = 20'd2000;
   localparam logic [CFG_W-1:0] AP_HOLD_RST    = 20'd3000;

   localparam logic [TMR_W-1:0] ALARM_MAX_MS = 22'd3600000;
   localparam logic [TMR_W-1:0] OFF_SHOW_MS  = 22'd2000;

endpackage

`default_nettype wire

>>> rtl/alarm_clock_menu_fsm_core.sv
// a beat accepted on req is held in the input register, then in the result register, where it is offered on rsp
// one event per cycle unless rsp stalls; the screen state updates as a beat moves to the result stage
// ready on req follows rsp_ready combinationally through the input stage
// reset: synchronous, active high; screen goes to clock, registers to their defaults,
// both stages empty
`timescale 1ns / 1ps
`default_nettype none

module alarm_clock_menu_fsm_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [acmf_pkg::CFG_IDX_W-1:0]      csr_index,
   input  wire logic [acmf_pkg::CFG_W-1:0]          csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [acmf_pkg::MODE_W-1:0]         req_mode,
   input  wire logic                                req_button_held,
   input  wire logic                                req_alarm_due,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [acmf_pkg::SCREEN_W-1:0]            rsp_screen,
   output logic                                     rsp_timer_load,
   output logic [acmf_pkg::TMR_W-1:0]               rsp_timer_ms,
   output logic                                     rsp_toggle_alarm,
   output logic                                     rsp_stop_sound,
   output logic                                     rsp_snooze,
   output logic                                     rsp_alarm_disable,
   output logic                                     rsp_open_ap,
   output logic [acmf_pkg::ADJ_W-1:0]               rsp_adjust_target,
   output logic signed [acmf_pkg::DIR_W-1:0]        rsp_adjust_dir,
   output logic                                     rsp_store_settings
);
   import acmf_pkg::*;

   typedef enum logic [SCREEN_W-1:0] {
      SCR_CLOCK  = 4'd0,
      SCR_TITLE  = 4'd1,
      SCR_SET    = 4'd2,
      SCR_RING   = 4'd3,
      SCR_RINGPR = 4'd4,
      SCR_OFF    = 4'd5,
      SCR_SLEEP  = 4'd6,
      SCR_BRIGHT = 4'd7,
      SCR_AP     = 4'd8,
      SCR_APPR   = 4'd9
   } screen_type;

   // configuration
   logic [CFG_W-1:0] short_menu_ff;
   logic [CFG_W-1:0] menu_ff;
   logic [CFG_W-1:0] alarm_hold_ff;
   logic [CFG_W-1:0] ap_hold_ff;

   // input stage
   logic              in_valid_ff;
   logic [MODE_W-1:0] in_mode_ff;
   logic              in_held_ff;
   logic              in_due_ff;

   // state and result stage
   screen_type              screen_ff;
   screen_type              screen_in;
   logic                    out_valid_ff;
   logic [SCREEN_W-1:0]     out_screen_ff;
   logic                    out_load_ff;
   logic                    out_load_in;
   logic [TMR_W-1:0]        out_ms_ff;
   logic [TMR_W-1:0]        out_ms_in;
   logic                    out_toggle_ff;
   logic                    out_toggle_in;
   logic                    out_stop_ff;
   logic                    out_stop_in;
   logic                    out_snooze_ff;
   logic                    out_snooze_in;
   logic                    out_disable_ff;
   logic                    out_disable_in;
   logic                    out_ap_ff;
   logic                    out_ap_in;
   logic [ADJ_W-1:0]        out_target_ff;
   logic [ADJ_W-1:0]        out_target_in;
   logic signed [DIR_W-1:0] out_dir_ff;
   logic signed [DIR_W-1:0] out_dir_in;
   logic                    out_store_ff;
   logic                    out_store_in;

   logic                    advance;
   logic signed [DIR_W-1:0] knob_dir;
   logic [TMR_W-1:0]        short_menu_tmr;
   logic [TMR_W-1:0]        menu_tmr;
   logic [TMR_W-1:0]        alarm_hold_tmr;
   logic [TMR_W-1:0]        ap_hold_tmr;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign knob_dir       = (in_mode_ff == MODE_KNOB_UP) ? DIR_UP : DIR_DOWN;
   assign short_menu_tmr = TMR_W'(short_menu_ff);
   assign menu_tmr       = TMR_W'(menu_ff);
   assign alarm_hold_tmr = TMR_W'(alarm_hold_ff);
   assign ap_hold_tmr    = TMR_W'(ap_hold_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         short_menu_ff <= SHORT_MENU_RST;
         menu_ff       <= MENU_RST;
         alarm_hold_ff <= ALARM_HOLD_RST;
         ap_hold_ff    <= AP_HOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_SHORT_MENU: short_menu_ff <= csr_wdata;
            CFG_MENU:       menu_ff       <= csr_wdata;
            CFG_ALARM_HOLD: alarm_hold_ff <= csr_wdata;
            CFG_AP_HOLD:    ap_hold_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // transition and action decode for the beat in the input stage
   always_comb begin
      screen_in      = screen_ff;
      out_load_in    = 1'b0;
      out_ms_in      = '0;
      out_toggle_in  = 1'b0;
      out_stop_in    = 1'b0;
      out_snooze_in  = 1'b0;
      out_disable_in = 1'b0;
      out_ap_in      = 1'b0;
      out_target_in  = ADJ_NONE;
      out_dir_in     = DIR_NONE;
      out_store_in   = 1'b0;
      unique case (in_mode_ff)
         MODE_PRESS: begin
            unique case (screen_ff)
               SCR_CLOCK: begin
                  screen_in   = SCR_TITLE;
                  out_load_in = 1'b1;
                  out_ms_in   = short_menu_tmr;
               end
               SCR_TITLE: begin
                  screen_in   = SCR_SLEEP;
                  out_load_in = 1'b1;
                  out_ms_in   = menu_tmr;
               end
               SCR_SET: begin
                  out_toggle_in = 1'b1;
                  out_load_in   = 1'b1;
                  out_ms_in     = menu_tmr;
               end
               SCR_SLEEP: begin
                  screen_in   = SCR_BRIGHT;
                  out_load_in = 1'b1;
                  out_ms_in   = menu_tmr;
               end
               SCR_BRIGHT: begin
                  screen_in   = SCR_AP;
                  out_load_in = 1'b1;
                  out_ms_in   = menu_tmr;
               end
               SCR_RING: begin
                  out_stop_in   = 1'b1;
                  out_snooze_in = 1'b1;
                  screen_in     = SCR_RINGPR;
                  out_load_in   = 1'b1;
                  out_ms_in     = alarm_hold_tmr;
               end
               SCR_AP: begin
                  screen_in   = SCR_APPR;
                  out_load_in = 1'b1;
                  out_ms_in   = ap_hold_tmr;
               end
               SCR_APPR: screen_in = SCR_CLOCK;
               default: ;
            endcase
         end
         MODE_RELEASE: begin
            if (screen_ff == SCR_APPR) screen_in = SCR_CLOCK;
         end
         MODE_TICK: begin
            if (in_due_ff) begin
               screen_in   = SCR_RING;
               out_load_in = 1'b1;
               out_ms_in   = ALARM_MAX_MS;
            end
            out_target_in = ADJ_AUTO;
            out_store_in  = 1'b1;
         end
         MODE_KNOB_UP, MODE_KNOB_DOWN: begin
            unique case (screen_ff)
               SCR_SET: begin
                  out_target_in = ADJ_ALARM;
                  out_dir_in    = knob_dir;
                  out_load_in   = 1'b1;
                  out_ms_in     = menu_tmr;
               end
               SCR_SLEEP: begin
                  out_target_in = ADJ_SNOOZE;
                  out_dir_in    = knob_dir;
                  out_load_in   = 1'b1;
                  out_ms_in     = menu_tmr;
               end
               SCR_BRIGHT: begin
                  out_target_in = ADJ_BRIGHT;
                  out_dir_in    = knob_dir;
                  out_load_in   = 1'b1;
                  out_ms_in     = menu_tmr;
               end
               default: ;
            endcase
         end
         MODE_EXPIRED: begin
            unique case (screen_ff)
               SCR_TITLE: begin
                  screen_in   = SCR_SET;
                  out_load_in = 1'b1;
                  out_ms_in   = menu_tmr;
               end
               SCR_RING: begin
                  out_stop_in    = 1'b1;
                  out_disable_in = 1'b1;
                  screen_in      = SCR_CLOCK;
               end
               SCR_RINGPR: begin
                  if (in_held_ff) begin
                     out_disable_in = 1'b1;
                     screen_in      = SCR_OFF;
                     out_load_in    = 1'b1;
                     out_ms_in      = OFF_SHOW_MS;
                  end else begin
                     screen_in = SCR_CLOCK;
                  end
               end
               SCR_APPR: begin
                  out_ap_in = in_held_ff;
                  screen_in = SCR_CLOCK;
               end
               default: screen_in = SCR_CLOCK;
            endcase
         end
         // unused event codes leave everything as is
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         screen_ff    <= SCR_CLOCK;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            screen_ff    <= screen_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff <= req_mode;
         in_held_ff <= req_button_held;
         in_due_ff  <= req_alarm_due;
      end
      if (advance) begin
         out_screen_ff  <= screen_in;
         out_load_ff    <= out_load_in;
         out_ms_ff      <= out_ms_in;
         out_toggle_ff  <= out_toggle_in;
         out_stop_ff    <= out_stop_in;
         out_snooze_ff  <= out_snooze_in;
         out_disable_ff <= out_disable_in;
         out_ap_ff      <= out_ap_in;
         out_target_ff  <= out_target_in;
         out_dir_ff     <= out_dir_in;
         out_store_ff   <= out_store_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_screen         = out_screen_ff;
   assign rsp_timer_load     = out_load_ff;
   assign rsp_timer_ms       = out_ms_ff;
   assign rsp_toggle_alarm   = out_toggle_ff;
   assign rsp_stop_sound     = out_stop_ff;
   assign rsp_snooze         = out_snooze_ff;
   assign rsp_alarm_disable  = out_disable_ff;
   assign rsp_open_ap        = out_ap_ff;
   assign rsp_adjust_target  = out_target_ff;
   assign rsp_adjust_dir     = out_dir_ff;
   assign rsp_store_settings = out_store_ff;

endmodule

`default_nettype wire

>>> verif/acmf_screen_check.sv
`timescale 1ns / 1ps
// acmf_screen_check: watches the event and result channels of the menu controller,
// tracks its own screen state and timeout registers, predicts every result beat and compares it
// depends on acmf_pkg only
module acmf_screen_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [acmf_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [acmf_pkg::CFG_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [acmf_pkg::MODE_W-1:0]          req_mode,
   input  logic                                 req_button_held,
   input  logic                                 req_alarm_due,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [acmf_pkg::SCREEN_W-1:0]        rsp_screen,
   input  logic                                 rsp_timer_load,
   input  logic [acmf_pkg::TMR_W-1:0]           rsp_timer_ms,
   input  logic                                 rsp_toggle_alarm,
   input  logic                                 rsp_stop_sound,
   input  logic                                 rsp_snooze,
   input  logic                                 rsp_alarm_disable,
   input  logic                                 rsp_open_ap,
   input  logic [acmf_pkg::ADJ_W-1:0]           rsp_adjust_target,
   input  logic signed [acmf_pkg::DIR_W-1:0]    rsp_adjust_dir,
   input  logic                                 rsp_store_settings,
   output int unsigned                          mismatches,
   output int unsigned                          backlog
);
   import acmf_pkg::*;

   typedef enum logic [SCREEN_W-1:0] {
      SCR_CLOCK        = 4'd0,
      SCR_TITLE        = 4'd1,
      SCR_SET          = 4'd2,
      SCR_RING         = 4'd3,
      SCR_RING_PRESSED = 4'd4,
      SCR_OFF          = 4'd5,
      SCR_SLEEP        = 4'd6,
      SCR_BRIGHT       = 4'd7,
      SCR_AP           = 4'd8,
      SCR_AP_PRESSED   = 4'd9
   } screen_type;

   typedef struct packed {
      logic [SCREEN_W-1:0]     screen;
      logic                    timer_load;
      logic [TMR_W-1:0]        timer_ms;
      logic                    toggle_alarm;
      logic                    stop_sound;
      logic                    snooze;
      logic                    alarm_disable;
      logic                    open_ap;
      logic [ADJ_W-1:0]        adjust_target;
      logic signed [DIR_W-1:0] adjust_dir;
      logic                    store_settings;
   } menu_result_type;

   screen_type       screen_now;
   logic [CFG_W-1:0] timeout_ms [4];
   menu_result_type  pending_results [$];
   int unsigned      fail_count = 0;
   int unsigned      queued = 0;

   assign mismatches = fail_count;
   assign backlog    = queued;

   function automatic menu_result_type with_timer(menu_result_type r, logic [TMR_W-1:0] ms);
      r.timer_load = 1'b1;
      r.timer_ms   = ms;
      return r;
   endfunction

   // advances screen_now by one event and returns the result beat it should produce
   function automatic menu_result_type predict_event(logic [MODE_W-1:0] mode, logic held,
                                                     logic due);
      menu_result_type         r;
      screen_type              s;
      logic signed [DIR_W-1:0] step;
      logic [TMR_W-1:0]        menu_t;
      r      = '0;
      s      = screen_now;
      step   = (mode == MODE_KNOB_UP) ? DIR_UP : DIR_DOWN;
      menu_t = TMR_W'(timeout_ms[CFG_MENU]);
      case (mode)
         MODE_PRESS: begin
            case (s)
               SCR_CLOCK: begin
                  s = SCR_TITLE;
                  r = with_timer(r, TMR_W'(timeout_ms[CFG_SHORT_MENU]));
               end
               SCR_TITLE: begin
                  s = SCR_SLEEP;
                  r = with_timer(r, menu_t);
               end
               SCR_SET: begin
                  r.toggle_alarm = 1'b1;
                  r = with_timer(r, menu_t);
               end
               SCR_SLEEP: begin
                  s = SCR_BRIGHT;
                  r = with_timer(r, menu_t);
               end
               SCR_BRIGHT: begin
                  s = SCR_AP;
                  r = with_timer(r, menu_t);
               end
               SCR_RING: begin
                  r.stop_sound = 1'b1;
                  r.snooze     = 1'b1;
                  s = SCR_RING_PRESSED;
                  r = with_timer(r, TMR_W'(timeout_ms[CFG_ALARM_HOLD]));
               end
               SCR_AP: begin
                  s = SCR_AP_PRESSED;
                  r = with_timer(r, TMR_W'(timeout_ms[CFG_AP_HOLD]));
               end
               // second press leaves the access point screen with no timer
               SCR_AP_PRESSED: s = SCR_CLOCK;
               default: ;
            endcase
         end
         MODE_RELEASE: begin
            if (s == SCR_AP_PRESSED) s = SCR_CLOCK;
         end
         MODE_TICK: begin
            // a due alarm restarts ringing even if it is already ringing
            if (due) begin
               s = SCR_RING;
               r = with_timer(r, ALARM_MAX_MS);
            end
            r.adjust_target  = ADJ_AUTO;
            r.adjust_dir     = DIR_NONE;
            r.store_settings = 1'b1;
         end
         MODE_KNOB_UP, MODE_KNOB_DOWN: begin
            if (s == SCR_SET || s == SCR_SLEEP || s == SCR_BRIGHT) begin
               r.adjust_target = (s == SCR_SET) ? ADJ_ALARM :
                                 (s == SCR_SLEEP) ? ADJ_SNOOZE : ADJ_BRIGHT;
               r.adjust_dir    = step;
               r = with_timer(r, menu_t);
            end
         end
         MODE_EXPIRED: begin
            case (s)
               SCR_TITLE: begin
                  s = SCR_SET;
                  r = with_timer(r, menu_t);
               end
               SCR_RING: begin
                  r.stop_sound    = 1'b1;
                  r.alarm_disable = 1'b1;
                  s = SCR_CLOCK;
               end
               SCR_RING_PRESSED: begin
                  if (held) begin
                     r.alarm_disable = 1'b1;
                     s = SCR_OFF;
                     r = with_timer(r, OFF_SHOW_MS);
                  end else begin
                     s = SCR_CLOCK;
                  end
               end
               SCR_AP_PRESSED: begin
                  r.open_ap = held;
                  s = SCR_CLOCK;
               end
               // plain screens fall back to the clock without a timer
               default: s = SCR_CLOCK;
            endcase
         end
         default: ;
      endcase
      screen_now = s;
      r.screen   = s;
      return r;
   endfunction

   task automatic check_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      menu_result_type want;
      if (reset) begin
         screen_now = SCR_CLOCK;
         timeout_ms[CFG_SHORT_MENU] = SHORT_MENU_RST;
         timeout_ms[CFG_MENU]       = MENU_RST;
         timeout_ms[CFG_ALARM_HOLD] = ALARM_HOLD_RST;
         timeout_ms[CFG_AP_HOLD]    = AP_HOLD_RST;
         pending_results.delete();
      end else begin
         if (csr_we) timeout_ms[csr_index] = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result beat with nothing expected, screen %0d", rsp_screen);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("screen", want.screen, rsp_screen);
               check_field("timer_load", want.timer_load, rsp_timer_load);
               check_field("timer_ms", want.timer_ms, rsp_timer_ms);
               check_field("toggle_alarm", want.toggle_alarm, rsp_toggle_alarm);
               check_field("stop_sound", want.stop_sound, rsp_stop_sound);
               check_field("snooze", want.snooze, rsp_snooze);
               check_field("alarm_disable", want.alarm_disable, rsp_alarm_disable);
               check_field("open_ap", want.open_ap, rsp_open_ap);
               check_field("adjust_target", want.adjust_target, rsp_adjust_target);
               check_field("adjust_dir", $unsigned(want.adjust_dir),
                           $unsigned(rsp_adjust_dir));
               check_field("store_settings", want.store_settings, rsp_store_settings);
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(predict_event(req_mode, req_button_held,
                                                    req_alarm_due));
      end
      queued = pending_results.size();
   end

endmodule

>>> verif/alarm_clock_menu_fsm_core_tb.sv
`timescale 1ns / 1ps
// alarm_clock_menu_fsm_core_tb: drives event beats, result back-pressure and timeout registers
// into the menu controller; acmf_screen_check does the prediction and comparison
// depends on acmf_pkg, alarm_clock_menu_fsm_core and acmf_screen_check
module alarm_clock_menu_fsm_core_tb;
   import acmf_pkg::*;

   // event codes the block does not define
   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
   localparam logic [CFG_W-1:0]  MS_LOW       = 20'd1;
   localparam logic [CFG_W-1:0]  MS_HIGH      = 20'd600000;
   localparam logic [CFG_W-1:0]  MS_ZERO      = 20'd0;
   localparam logic [CFG_W-1:0]  MS_ALL_ONES  = 20'hFFFFF;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CFG_IDX_W-1:0]    csr_index = '0;
   logic [CFG_W-1:0]        csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [MODE_W-1:0]       req_mode = '0;
   logic                    req_button_held = 1'b0;
   logic                    req_alarm_due = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [SCREEN_W-1:0]     rsp_screen;
   logic                    rsp_timer_load;
   logic [TMR_W-1:0]        rsp_timer_ms;
   logic                    rsp_toggle_alarm;
   logic                    rsp_stop_sound;
   logic                    rsp_snooze;
   logic                    rsp_alarm_disable;
   logic                    rsp_open_ap;
   logic [ADJ_W-1:0]        rsp_adjust_target;
   logic signed [DIR_W-1:0] rsp_adjust_dir;
   logic                    rsp_store_settings;
   int unsigned             mismatches;
   int unsigned             backlog;

   // when set, neither side inserts gaps
   bit                      steady = 1'b0;

   alarm_clock_menu_fsm_core dut (.*);

   acmf_screen_check screen_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // result side back-pressure, one draw per beat
   initial begin : rsp_side
      int unsigned stall;
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic put_event(logic [MODE_W-1:0] mode, logic held, logic due);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_button_held <= held;
      req_alarm_due   <= due;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic drain_events();
      req_valid <= 1'b0;
      while (backlog != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic program_timeouts(logic [CFG_W-1:0] short_ms, logic [CFG_W-1:0] menu_ms,
                                   logic [CFG_W-1:0] hold_ms, logic [CFG_W-1:0] ap_ms);
      drain_events();
      csr_beat(CFG_SHORT_MENU, short_ms);
      csr_beat(CFG_MENU, menu_ms);
      csr_beat(CFG_ALARM_HOLD, hold_ms);
      csr_beat(CFG_AP_HOLD, ap_ms);
      csr_we <= 1'b0;
   endtask

   // press-heavy mix so the menu walk and the ringing path both get deep
   task automatic run_random(int unsigned count);
      int unsigned       pick;
      logic [MODE_W-1:0] mode;
      logic              held;
      logic              due;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 50 == 0) steady = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         held = 1'($urandom);
         due  = 1'($urandom);
         if (pick < 30) mode = MODE_PRESS;
         else if (pick < 38) mode = MODE_RELEASE;
         else if (pick < 50) begin
            mode = MODE_TICK;
            due  = ($urandom_range(0, 2) == 0);
         end
         else if (pick < 63) mode = MODE_KNOB_UP;
         else if (pick < 76) mode = MODE_KNOB_DOWN;
         else if (pick < 96) mode = MODE_EXPIRED;
         else mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
         put_event(mode, held, due);
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk with the reset timeouts
      put_event(MODE_SPARE_A, 1'b0, 1'b0);
      put_event(MODE_SPARE_B, 1'b1, 1'b1);
      put_event(MODE_PRESS, 1'b0, 1'b0);
      put_event(MODE_EXPIRED, 1'b0, 1'b0);
      put_event(MODE_KNOB_UP, 1'b0, 1'b0);
      put_event(MODE_KNOB_DOWN, 1'b0, 1'b0);
      put_event(MODE_PRESS, 1'b1, 1'b0);
      put_event(MODE_EXPIRED, 1'b0, 1'b0);
      put_event(MODE_TICK, 1'b0, 1'b0);
      put_event(MODE_TICK, 1'b0, 1'b1);
      // alarm due again while already ringing
      put_event(MODE_TICK, 1'b1, 1'b1);
      put_event(MODE_PRESS, 1'b1, 1'b0);
      put_event(MODE_EXPIRED, 1'b1, 1'b0);
      put_event(MODE_EXPIRED, 1'b0, 1'b0);
      put_event(MODE_TICK, 1'b0, 1'b1);
      put_event(MODE_EXPIRED, 1'b0, 1'b0);
      put_event(MODE_TICK, 1'b0, 1'b1);
      put_event(MODE_PRESS, 1'b1, 1'b0);
      put_event(MODE_EXPIRED, 1'b0, 1'b0);
      put_event(MODE_PRESS, 1'b1, 1'b0);
      put_event(MODE_PRESS, 1'b1, 1'b0);
      put_event(MODE_KNOB_UP, 1'b0, 1'b0);
      put_event(MODE_PRESS, 1'b1, 1'b0);
      put_event(MODE_KNOB_DOWN, 1'b0, 1'b0);
      put_event(MODE_PRESS, 1'b1, 1'b0);
      put_event(MODE_PRESS, 1'b1, 1'b0);
      put_event(MODE_PRESS, 1'b1, 1'b0);
      run_random(250);

      program_timeouts(MS_LOW, MS_LOW, MS_LOW, MS_LOW);
      run_random(200);
      program_timeouts(MS_HIGH, MS_HIGH, MS_HIGH, MS_HIGH);
      run_random(200);
      // out-of-range values are used as written
      program_timeouts(MS_ZERO, MS_ALL_ONES, MS_ZERO, MS_ALL_ONES);
      run_random(200);
      program_timeouts(MS_ALL_ONES, MS_ZERO, MS_ALL_ONES, MS_ZERO);
      run_random(200);
      program_timeouts(CFG_W'($urandom_range(1, 600000)), CFG_W'($urandom_range(1, 600000)),
                       CFG_W'($urandom_range(1, 600000)), CFG_W'($urandom_range(1, 600000)));
      run_random(200);
      program_timeouts(CFG_W'($urandom_range(1, 600000)), CFG_W'($urandom_range(1, 600000)),
                       CFG_W'($urandom_range(1, 600000)), CFG_W'($urandom_range(1, 600000)));
      run_random(200);
      program_timeouts(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
      run_random(200);

      req_valid <= 1'b0;
      while (backlog != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0 && backlog == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
